// File: hdl/tmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg: shared types and constants
// Command codes, register indexes, widths and the controller/datapath bundles
// of the transposed matrix multiply block.
// ----------------------------------------------------------------------------
package tmm_pkg;

    localparam int SIZE_W     = 5;
    localparam int SIZE_MAX   = 31;
    localparam int RESULT_CAP = 16;
    localparam int IDX_W      = 4;
    localparam int ADDR_W     = 8;
    localparam int STORE_DEPTH = 256;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_USED = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             start;
        logic             issue;
        logic             step_k;
        logic             step_col;
        logic             first;
        logic             last;
        logic             last_col;
        logic [IDX_W-1:0] col;
    } dp_cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0] ni;
        logic [SIZE_W-1:0] nj;
        logic [SIZE_W-1:0] nk;
        logic              pipe_busy;
    } dp_status_t;

endpackage

// File: hdl/tmm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_ctrl: request sequencer
// Accepts requests, steps column and inner counters, drains the MAC pipeline.
// ----------------------------------------------------------------------------
module tmm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tmm_pkg::CMD_W-1:0]  command,
    input  logic [tmm_pkg::IDX_W-1:0]  row_select,
    input  tmm_pkg::dp_status_t        status,
    output tmm_pkg::dp_cmd_t           cmd,
    output logic                       busy
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [tmm_pkg::IDX_W-1:0]       j_reg, j_next;
    logic [tmm_pkg::SIZE_W-1:0]      k_reg, k_next;
    logic                            k_last, j_last, row_ok;

    assign k_last = (k_reg == status.nk - 1'b1);
    assign j_last = ({1'b0, j_reg} == status.nj - 1'b1);
    assign row_ok = ({1'b0, row_select} < status.ni);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.col    = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        tmm_pkg::CMD_LOAD_A: cmd.load_a = 1'b1;
                        tmm_pkg::CMD_LOAD_B: cmd.load_b = 1'b1;
                        tmm_pkg::CMD_COMPUTE:
                        begin
                            if (row_ok)
                            begin
                                cmd.start  = 1'b1;
                                j_next     = '0;
                                k_next     = '0;
                                state_next = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.issue    = 1'b1;
                cmd.first    = (k_reg == '0);
                cmd.last     = k_last;
                cmd.last_col = j_last;
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.step_col = 1'b1;
                        j_next       = j_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.step_k = 1'b1;
                    k_next     = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: hdl/tmm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_datapath: size registers, element stores, address generators and MAC
// Read -> multiply -> accumulate pipeline with a registered result output.
// ----------------------------------------------------------------------------
module tmm_datapath #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_INNER = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmm_pkg::SIZE_W-1:0]        cfg_data,
    input  logic [tmm_pkg::ADDR_W-1:0]        element_index,
    input  logic signed [tmm_pkg::ELEM_W-1:0] element_value,
    input  logic [tmm_pkg::IDX_W-1:0]         row_select,
    input  tmm_pkg::dp_cmd_t                  cmd,
    output tmm_pkg::dp_status_t               status,
    output logic                              result_valid,
    output logic signed [tmm_pkg::ACC_W-1:0]  result_value,
    output logic [tmm_pkg::IDX_W-1:0]         result_row,
    output logic [tmm_pkg::IDX_W-1:0]         result_col,
    output logic                              last_of_row
);

    localparam int ROW_CAP   = (MAX_ROWS < tmm_pkg::SIZE_MAX) ? MAX_ROWS : tmm_pkg::SIZE_MAX;
    localparam int COL_LIM   = (MAX_COLS < tmm_pkg::RESULT_CAP) ? MAX_COLS : tmm_pkg::RESULT_CAP;
    localparam int COL_CAP   = (COL_LIM < tmm_pkg::SIZE_MAX) ? COL_LIM : tmm_pkg::SIZE_MAX;
    localparam int INNER_CAP = (MAX_INNER < tmm_pkg::SIZE_MAX) ? MAX_INNER : tmm_pkg::SIZE_MAX;
    localparam int SW = tmm_pkg::SIZE_W;
    localparam int AW = tmm_pkg::ADDR_W;
    localparam int IW = tmm_pkg::IDX_W;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] top);
        logic [SW-1:0] r;
        if (v == '0)
            r = {{(SW-1){1'b0}}, 1'b1};
        else if (v > top)
            r = top;
        else
            r = v;
        return r;
    endfunction

    logic [SW-1:0] rows_used_reg, cols_used_reg, inner_used_reg;
    logic [SW-1:0] ni, nj, nk;

    logic [AW-1:0] a_addr_reg, b_addr_reg;
    logic [IW-1:0] row_reg, b_col_reg, b_col_inc;

    logic signed [tmm_pkg::ELEM_W-1:0] a_data, b_data;

    logic          s1_valid_reg, s1_first_reg, s1_last_reg, s1_last_col_reg;
    logic [IW-1:0] s1_col_reg;
    logic          s2_valid_reg, s2_first_reg, s2_last_reg, s2_last_col_reg;
    logic [IW-1:0] s2_col_reg;
    logic signed [tmm_pkg::PROD_W-1:0] prod_reg;
    logic signed [tmm_pkg::ACC_W-1:0]  acc_reg, acc_next;

    logic                              result_valid_reg;
    logic signed [tmm_pkg::ACC_W-1:0]  result_value_reg;
    logic [IW-1:0]                     result_row_reg, result_col_reg;
    logic                              last_of_row_reg;

    assign ni = clamp_size(rows_used_reg, SW'(ROW_CAP));
    assign nj = clamp_size(cols_used_reg, SW'(COL_CAP));
    assign nk = clamp_size(inner_used_reg, SW'(INNER_CAP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg  <= tmm_pkg::SIZE_RESET;
            cols_used_reg  <= tmm_pkg::SIZE_RESET;
            inner_used_reg <= tmm_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tmm_pkg::CFG_ROWS_USED:  rows_used_reg  <= cfg_data;
                tmm_pkg::CFG_COLS_USED:  cols_used_reg  <= cfg_data;
                tmm_pkg::CFG_INNER_USED: inner_used_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a index = k*ni + i, b index = k*nj + j, both wrapping at the store depth
    assign b_col_inc = b_col_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            row_reg    <= row_select;
            a_addr_reg <= {{(AW-IW){1'b0}}, row_select};
            b_addr_reg <= '0;
            b_col_reg  <= '0;
        end
        else if (cmd.step_k)
        begin
            a_addr_reg <= a_addr_reg + {{(AW-SW){1'b0}}, ni};
            b_addr_reg <= b_addr_reg + {{(AW-SW){1'b0}}, nj};
        end
        else if (cmd.step_col)
        begin
            a_addr_reg <= {{(AW-IW){1'b0}}, row_reg};
            b_addr_reg <= {{(AW-IW){1'b0}}, b_col_inc};
            b_col_reg  <= b_col_inc;
        end
    end

    tmm_ram #(
        .WIDTH (tmm_pkg::ELEM_W),
        .DEPTH (tmm_pkg::STORE_DEPTH)
    ) u_a_ram (
        .clk     (clk),
        .wr_en   (cmd.load_a),
        .wr_addr (element_index),
        .wr_data (element_value),
        .rd_en   (cmd.issue),
        .rd_addr (a_addr_reg),
        .rd_data (a_data)
    );

    tmm_ram #(
        .WIDTH (tmm_pkg::ELEM_W),
        .DEPTH (tmm_pkg::STORE_DEPTH)
    ) u_b_ram (
        .clk     (clk),
        .wr_en   (cmd.load_b),
        .wr_addr (element_index),
        .wr_data (element_value),
        .rd_en   (cmd.issue),
        .rd_addr (b_addr_reg),
        .rd_data (b_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= cmd.issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    assign acc_next = (s2_first_reg ? '0 : acc_reg)
                    + {{(tmm_pkg::ACC_W-tmm_pkg::PROD_W){prod_reg[tmm_pkg::PROD_W-1]}},
                       prod_reg};

    always_ff @(posedge clk)
    begin
        s1_first_reg    <= cmd.first;
        s1_last_reg     <= cmd.last;
        s1_last_col_reg <= cmd.last_col;
        s1_col_reg      <= cmd.col;

        prod_reg        <= a_data * b_data;
        s2_first_reg    <= s1_first_reg;
        s2_last_reg     <= s1_last_reg;
        s2_last_col_reg <= s1_last_col_reg;
        s2_col_reg      <= s1_col_reg;

        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
            if (s2_last_reg)
            begin
                result_value_reg <= acc_next;
                result_row_reg   <= row_reg;
                result_col_reg   <= s2_col_reg;
                last_of_row_reg  <= s2_last_col_reg;
            end
        end
    end

    assign status.ni        = ni;
    assign status.nj        = nj;
    assign status.nk        = nk;
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign result_row   = result_row_reg;
    assign result_col   = result_col_reg;
    assign last_of_row  = last_of_row_reg;

endmodule

// File: hdl/transposed_matrix_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposed_matrix_multiply_top: C = transpose(A) * B, one row per request
// Load requests write one Q8.8 element of A or B; compute requests stream
// one 48-bit Q32.16 result per column of the selected row.
// ----------------------------------------------------------------------------
// A load request leaves busy low. A compute request for
// row i holds busy high until its last result is out: one shared multiply-accumulate
// unit fed by one read port on each element store does one product per
// cycle, and a three-stage read/multiply/accumulate pipeline adds the tail.
// Results come one per column in column order, each on the result ports for
// exactly one cycle with result_valid high; the receiver cannot stall them.
// A compute request whose row is not below the clamped row count, and
// command 3, are dropped.
// The user must write size registers through cfg_write only while busy is low; the block does not enforce it.
// ----------------------------------------------------------------------------
module transposed_matrix_multiply_top #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int MAX_INNER = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmm_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [tmm_pkg::CMD_W-1:0]         command,
    input  logic [tmm_pkg::ADDR_W-1:0]        element_index,
    input  logic signed [tmm_pkg::ELEM_W-1:0] element_value,
    input  logic [tmm_pkg::IDX_W-1:0]         row_select,
    output logic                              result_valid,
    output logic signed [tmm_pkg::ACC_W-1:0]  result_value,
    output logic [tmm_pkg::IDX_W-1:0]         result_row,
    output logic [tmm_pkg::IDX_W-1:0]         result_col,
    output logic                              last_of_row
);

    tmm_pkg::dp_cmd_t    dp_cmd;
    tmm_pkg::dp_status_t dp_status;

    tmm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .row_select (row_select),
        .status     (dp_status),
        .cmd        (dp_cmd),
        .busy       (busy)
    );

    tmm_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_INNER (MAX_INNER)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_index (element_index),
        .element_value (element_value),
        .row_select    (row_select),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .result_valid  (result_valid),
        .result_value  (result_value),
        .result_row    (result_row),
        .result_col    (result_col),
        .last_of_row   (last_of_row)
    );

endmodule

// File: hdl/tmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_checker: port-level checks for transposed_matrix_multiply_top
// Relates requests, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module tmm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [tmm_pkg::CMD_W-1:0]         command,
    input logic                              result_valid,
    input logic                              last_of_row
);

    // results only while a compute request is in flight
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != tmm_pkg::CMD_COMPUTE) |=> !busy)
        else $error("non-compute request raised busy");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_row) |=> !result_valid)
        else $error("result after last of row");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_row) |=> busy)
        else $error("busy dropped before last result");

    a_fall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && last_of_row))
        else $error("busy fell without last result");

endmodule

bind transposed_matrix_multiply_top tmm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .last_of_row  (last_of_row)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: transposed_matrix_multiply_top
// Walks a short directed table (size extremes, element extremes, dropped
// requests) and then random load/compute traffic under several size
// settings. An in-bench mirror of the element stores and size registers
// predicts each C element; checked table steps replace it with their own
// expected value. A negedge monitor checks each result strobe in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ROWS_LIMIT  = 16;
    localparam int COLS_LIMIT  = 16;
    localparam int INNER_LIMIT = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int GROUP_ITEMS = 18;
    localparam int PLAN_LEN    = 27;

    localparam logic [tmm_pkg::CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [tmm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] { STEP_CFG, STEP_REQ, STEP_CHECKED } step_kind_t;

    typedef struct packed {
        step_kind_t                 kind;
        logic [1:0]                 code;
        logic [tmm_pkg::ADDR_W-1:0] index;
        logic [tmm_pkg::ELEM_W-1:0] value;
        logic [tmm_pkg::IDX_W-1:0]  row;
        logic                       n_exp;
        logic [tmm_pkg::ACC_W-1:0]  exp_value;
    } step_t;

    typedef struct {
        logic signed [tmm_pkg::ACC_W-1:0] value;
        logic [tmm_pkg::IDX_W-1:0]        row;
        logic [tmm_pkg::IDX_W-1:0]        col;
        logic                             last;
    } c_entry_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [tmm_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [tmm_pkg::SIZE_W-1:0]        cfg_data;
    logic                              start;
    logic                              busy;
    logic [tmm_pkg::CMD_W-1:0]         command;
    logic [tmm_pkg::ADDR_W-1:0]        element_index;
    logic signed [tmm_pkg::ELEM_W-1:0] element_value;
    logic [tmm_pkg::IDX_W-1:0]         row_select;
    logic                              result_valid;
    logic signed [tmm_pkg::ACC_W-1:0]  result_value;
    logic [tmm_pkg::IDX_W-1:0]         result_row;
    logic [tmm_pkg::IDX_W-1:0]         result_col;
    logic                              last_of_row;

    logic signed [tmm_pkg::ELEM_W-1:0] a_copy [tmm_pkg::STORE_DEPTH];
    logic signed [tmm_pkg::ELEM_W-1:0] b_copy [tmm_pkg::STORE_DEPTH];
    bit                                a_loaded [tmm_pkg::STORE_DEPTH];
    bit                                b_loaded [tmm_pkg::STORE_DEPTH];
    logic [tmm_pkg::SIZE_W-1:0]        rows_cfg;
    logic [tmm_pkg::SIZE_W-1:0]        cols_cfg;
    logic [tmm_pkg::SIZE_W-1:0]        inner_cfg;

    c_entry_t expected_c [$];
    int       mismatches = 0;
    int       stall_cycles = 0;
    int       sender_idle_pct = 8;
    step_t    plan [PLAN_LEN];

    transposed_matrix_multiply_top #(
        .MAX_ROWS  (ROWS_LIMIT),
        .MAX_COLS  (COLS_LIMIT),
        .MAX_INNER (INNER_LIMIT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .element_index (element_index),
        .element_value (element_value),
        .row_select    (row_select),
        .result_valid  (result_valid),
        .result_value  (result_value),
        .result_row    (result_row),
        .result_col    (result_col),
        .last_of_row   (last_of_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned effective_size(logic [tmm_pkg::SIZE_W-1:0] v,
                                                   int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : int'(v);
    endfunction

    function automatic logic [tmm_pkg::ELEM_W-1:0] pick_element();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return tmm_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    task automatic current_sizes(output int unsigned ni, output int unsigned nj,
                                 output int unsigned nk);
        ni = effective_size(rows_cfg, ROWS_LIMIT);
        nj = effective_size(cols_cfg, (COLS_LIMIT < tmm_pkg::RESULT_CAP) ?
                                      COLS_LIMIT : tmm_pkg::RESULT_CAP);
        nk = effective_size(inner_cfg, INNER_LIMIT);
    endtask

    // Update the mirrored stores and queue the C elements a request yields.
    task automatic mirror_request(input logic [tmm_pkg::CMD_W-1:0] cmd,
                                  input logic [tmm_pkg::ADDR_W-1:0] idx,
                                  input logic [tmm_pkg::ELEM_W-1:0] val,
                                  input logic [tmm_pkg::IDX_W-1:0] row,
                                  output int produced);
        int unsigned                       ni, nj, nk, ai, bi;
        logic signed [tmm_pkg::PROD_W-1:0] prod;
        c_entry_t                          e;
        produced = 0;
        current_sizes(ni, nj, nk);
        if (cmd == tmm_pkg::CMD_LOAD_A)
        begin
            a_copy[idx]   = val;
            a_loaded[idx] = 1'b1;
        end
        else if (cmd == tmm_pkg::CMD_LOAD_B)
        begin
            b_copy[idx]   = val;
            b_loaded[idx] = 1'b1;
        end
        else if (cmd == tmm_pkg::CMD_COMPUTE && row < ni)
        begin
            for (int unsigned j = 0; j < nj; j++)
            begin
                e.value = '0;
                for (int unsigned k = 0; k < nk; k++)
                begin
                    ai      = (k * ni + row) % tmm_pkg::STORE_DEPTH;
                    bi      = (k * nj + j) % tmm_pkg::STORE_DEPTH;
                    prod    = a_copy[ai] * b_copy[bi];
                    e.value = e.value + prod;
                end
                e.row  = row;
                e.col  = j[tmm_pkg::IDX_W-1:0];
                e.last = (j + 1 == nj);
                expected_c.push_back(e);
                produced++;
            end
        end
    endtask

    task automatic send_request(input logic [tmm_pkg::CMD_W-1:0] cmd,
                                input logic [tmm_pkg::ADDR_W-1:0] idx,
                                input logic [tmm_pkg::ELEM_W-1:0] val,
                                input logic [tmm_pkg::IDX_W-1:0] row,
                                output int produced);
        bit taken;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start         <= 1'b1;
        command       <= cmd;
        element_index <= idx;
        element_value <= val;
        row_select    <= row;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        mirror_request(cmd, idx, val, row, produced);
    endtask

    // Load any store entry a compute of this row would read before it is set.
    task automatic fill_operands(input logic [tmm_pkg::IDX_W-1:0] row);
        int unsigned ni, nj, nk, adr;
        int          produced;
        current_sizes(ni, nj, nk);
        if (row < ni)
        begin
            for (int unsigned k = 0; k < nk; k++)
            begin
                adr = (k * ni + row) % tmm_pkg::STORE_DEPTH;
                if (!a_loaded[adr])
                    send_request(tmm_pkg::CMD_LOAD_A, adr[tmm_pkg::ADDR_W-1:0],
                                 pick_element(), tmm_pkg::IDX_W'($urandom), produced);
                for (int unsigned j = 0; j < nj; j++)
                begin
                    adr = (k * nj + j) % tmm_pkg::STORE_DEPTH;
                    if (!b_loaded[adr])
                        send_request(tmm_pkg::CMD_LOAD_B, adr[tmm_pkg::ADDR_W-1:0],
                                     pick_element(), tmm_pkg::IDX_W'($urandom), produced);
                end
            end
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_c.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic write_size(input logic [tmm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tmm_pkg::SIZE_W-1:0] data);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            tmm_pkg::CFG_ROWS_USED:  rows_cfg  = data;
            tmm_pkg::CFG_COLS_USED:  cols_cfg  = data;
            tmm_pkg::CFG_INNER_USED: inner_cfg = data;
            default: ;
        endcase
    endtask

    initial
    begin
        step_t                      s;
        int                         produced;
        logic [tmm_pkg::IDX_W-1:0]  row;
        logic [tmm_pkg::SIZE_W-1:0] gr, gc, gi;

        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        start         <= 1'b0;
        command       <= '0;
        element_index <= '0;
        element_value <= '0;
        row_select    <= '0;
        rows_cfg  = tmm_pkg::SIZE_RESET;
        cols_cfg  = tmm_pkg::SIZE_RESET;
        inner_cfg = tmm_pkg::SIZE_RESET;

        plan = '{
            '{STEP_CFG,     tmm_pkg::CFG_ROWS_USED,  8'h00, 16'd0,    4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_COLS_USED,  8'h00, 16'd0,    4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_INNER_USED, 8'h00, 16'd0,    4'd0,  1'b0, 48'd0},
            '{STEP_REQ,     tmm_pkg::CMD_LOAD_A,     8'h00, 16'h7FFF, 4'd0,  1'b0, 48'd0},
            '{STEP_REQ,     tmm_pkg::CMD_LOAD_B,     8'h00, 16'h7FFF, 4'd0,  1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd0,  1'b1,
              48'h0000_3FFF_0001},
            '{STEP_REQ,     tmm_pkg::CMD_LOAD_A,     8'h00, 16'h8000, 4'd0,  1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd0,  1'b1,
              48'hFFFF_C000_8000},
            '{STEP_REQ,     tmm_pkg::CMD_LOAD_B,     8'h00, 16'h8000, 4'd0,  1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd0,  1'b1,
              48'h0000_4000_0000},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd15, 1'b0, 48'd0},
            '{STEP_CHECKED, CMD_UNUSED,              8'hFF, 16'h7FFF, 4'd15, 1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd0,  1'b1,
              48'h0000_4000_0000},
            '{STEP_CFG,     CFG_UNUSED,              8'h00, 16'd31,   4'd0,  1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd1,  1'b0, 48'd0},
            '{STEP_REQ,     tmm_pkg::CMD_LOAD_A,     8'h00, 16'h0000, 4'd0,  1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd0,  1'b1, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_ROWS_USED,  8'h00, 16'd31,   4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_COLS_USED,  8'h00, 16'd31,   4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_INNER_USED, 8'h00, 16'd1,    4'd0,  1'b0, 48'd0},
            '{STEP_REQ,     tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd15, 1'b0, 48'd0},
            '{STEP_REQ,     tmm_pkg::CMD_COMPUTE,    8'hFF, 16'hFFFF, 4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_ROWS_USED,  8'h00, 16'd3,    4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_COLS_USED,  8'h00, 16'd1,    4'd0,  1'b0, 48'd0},
            '{STEP_CFG,     tmm_pkg::CFG_INNER_USED, 8'h00, 16'd31,   4'd0,  1'b0, 48'd0},
            '{STEP_REQ,     tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd2,  1'b0, 48'd0},
            '{STEP_CHECKED, tmm_pkg::CMD_COMPUTE,    8'h00, 16'd0,    4'd3,  1'b0, 48'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            s = plan[n];
            if (s.kind == STEP_CFG)
                write_size(s.code, s.value[tmm_pkg::SIZE_W-1:0]);
            else
            begin
                if (s.code == tmm_pkg::CMD_COMPUTE)
                    fill_operands(s.row);
                send_request(s.code, s.index, s.value, s.row, produced);
                if (s.kind == STEP_CHECKED)
                begin
                    repeat (produced) void'(expected_c.pop_back());
                    if (s.n_exp)
                        expected_c.push_back('{s.exp_value, s.row, 4'd0, 1'b1});
                end
            end
        end

        for (int g = 0; g < 3; g++)
        begin
            sender_idle_pct = (g == 0) ? 8 : (g == 1) ? 66 : 0;
            case (g)
                0: begin gr = 5'd4; gc = 5'd4; gi = 5'd4; end
                1: begin gr = 5'd3; gc = 5'd5; gi = 5'd3; end
                default:
                begin
                    gr = tmm_pkg::SIZE_W'($urandom_range(6));
                    gc = tmm_pkg::SIZE_W'($urandom_range(6));
                    gi = tmm_pkg::SIZE_W'($urandom_range(6));
                end
            endcase
            write_size(tmm_pkg::CFG_ROWS_USED, gr);
            write_size(tmm_pkg::CFG_COLS_USED, gc);
            write_size(tmm_pkg::CFG_INNER_USED, gi);
            repeat (GROUP_ITEMS)
            begin
                row = tmm_pkg::IDX_W'($urandom);
                case ($urandom_range(19))
                    0, 1:
                        send_request(CMD_UNUSED, tmm_pkg::ADDR_W'($urandom),
                                     tmm_pkg::ELEM_W'($urandom), row, produced);
                    2, 3, 4, 5, 6:
                        send_request(tmm_pkg::CMD_LOAD_A, tmm_pkg::ADDR_W'($urandom),
                                     pick_element(), row, produced);
                    7, 8, 9, 10, 11:
                        send_request(tmm_pkg::CMD_LOAD_B, tmm_pkg::ADDR_W'($urandom),
                                     pick_element(), row, produced);
                    default:
                    begin
                        fill_operands(row);
                        send_request(tmm_pkg::CMD_COMPUTE, tmm_pkg::ADDR_W'($urandom),
                                     tmm_pkg::ELEM_W'($urandom), row, produced);
                    end
                endcase
            end
        end

        settle();
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("PASS transposed_matrix_multiply_top");
        else
            $display("FAIL transposed_matrix_multiply_top");
        $finish;
    end

    // Result check and stall watchdog, sampled mid-cycle.
    always @(negedge clk)
    begin
        c_entry_t want;
        if (rst_n && result_valid)
        begin
            if (expected_c.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d value %0h",
                       result_row, result_col, result_value);
                mismatches++;
            end
            else
            begin
                want = expected_c.pop_front();
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0h, got %0h", want.value, result_value);
                    mismatches++;
                end
                if (result_row !== want.row)
                begin
                    $error("result_row: expected %0d, got %0d", want.row, result_row);
                    mismatches++;
                end
                if (result_col !== want.col)
                begin
                    $error("result_col: expected %0d, got %0d", want.col, result_col);
                    mismatches++;
                end
                if (last_of_row !== want.last)
                begin
                    $error("last_of_row: expected %0d, got %0d", want.last, last_of_row);
                    mismatches++;
                end
            end
        end
        if (result_valid || (start && !busy))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL transposed_matrix_multiply_top");
            $finish;
        end
    end

endmodule

// File: sim.f
hdl/tmm_pkg.sv
hdl/tmm_ram.sv
hdl/tmm_ctrl.sv
hdl/tmm_datapath.sv
hdl/transposed_matrix_multiply_top.sv
hdl/tmm_checker.sv
tb/testbench.sv
